### rtl/hsc_pkg.sv
// shared constants, codes and bit-mapping functions for the secded codec
`timescale 1ns / 1ps

package hsc_pkg;

	// port widths of the payload fields
	localparam int DATA_W = 57;
	localparam int CODE_W = 64;

	// code geometry: data bits carried and code bits including overall parity
	localparam int DATA_BITS = 57;
	localparam int CODE_BITS = 64;

	// syndrome width: enough bits to name every position below CODE_BITS
	localparam int SYN_W = $clog2(CODE_BITS);

	// operation codes of the mode field
	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CORRECTED = 2'd1,
		ST_DOUBLE    = 2'd2
	} status_t;

	// true for positions that hold a check bit
	function automatic logic is_pow2(input int p);
		return (p & (p - 1)) == 0;
	endfunction

	// xor of the numbers of all positions 1..CODE_BITS-1 that hold a one
	function automatic logic [SYN_W-1:0] syndrome(input logic [CODE_BITS-1:0] cw);
		logic [SYN_W-1:0] syn;
		syn = '0;
		for (int pos = 1; pos < CODE_BITS; pos++) begin
			if (cw[pos-1]) begin
				syn ^= SYN_W'(pos);
			end
		end
		return syn;
	endfunction

	// place data bits at the non-power-of-two positions in ascending order
	function automatic logic [CODE_BITS-1:0] scatter(input logic [DATA_BITS-1:0] data);
		logic [CODE_BITS-1:0] cw;
		int d;
		cw = '0;
		d = 0;
		for (int pos = 1; pos < CODE_BITS; pos++) begin
			if (!is_pow2(pos) && d < DATA_BITS) begin
				cw[pos-1] = data[d];
				d++;
			end
		end
		return cw;
	endfunction

	// pull the data bits back out of the non-power-of-two positions
	function automatic logic [DATA_BITS-1:0] gather(input logic [CODE_BITS-1:0] cw);
		logic [DATA_BITS-1:0] data;
		int d;
		data = '0;
		d = 0;
		for (int pos = 1; pos < CODE_BITS; pos++) begin
			if (!is_pow2(pos) && d < DATA_BITS) begin
				data[d] = cw[pos-1];
				d++;
			end
		end
		return data;
	endfunction

endpackage

### rtl/hamming_secded_codec_unit.sv
// extended hamming secded encoder and checker/corrector, one word per clock
// result strobe (done): start is taken into the input register, then done comes from the result register
// throughput: one transaction per cycle, busy is always low; the xor trees lie
// between the input register and the result register
// reset: arst_n clears the input and result valid flags; payload registers are not reset
// the receiver cannot stall, so each result is shown for exactly one cycle
`timescale 1ns / 1ps

module hamming_secded_codec_unit
	import hsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [DATA_W-1:0] data_in,
	input  logic [CODE_W-1:0] code_in,
	output logic              done,
	output logic [CODE_W-1:0] code_out,
	output logic [DATA_W-1:0] data_out,
	output logic [1:0]        status
);

	logic                 valid_s1;
	logic                 mode_s1;
	logic [DATA_BITS-1:0] data_s1;
	logic [CODE_BITS-1:0] code_s1;

	logic [CODE_BITS-1:0] enc_cw;
	logic [CODE_BITS-1:0] dec_cw;
	logic [SYN_W-1:0]     enc_syn;
	logic [SYN_W-1:0]     dec_syn;
	logic                 dec_par;
	status_t              dec_status;

	logic [CODE_W-1:0]    code_nxt;
	logic [DATA_W-1:0]    data_nxt;
	status_t              status_nxt;

	logic                 done_q;
	logic [CODE_W-1:0]    code_q;
	logic [DATA_W-1:0]    data_q;
	status_t              status_q;

	// no stall source, a new transaction is taken every cycle
	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1 <= mode;
			data_s1 <= data_in[DATA_BITS-1:0];
			code_s1 <= code_in[CODE_BITS-1:0];
		end
	end

	// encode: scatter data, fill check bits from syndrome, then overall parity
	always_comb begin
		enc_cw  = scatter(data_s1);
		enc_syn = syndrome(enc_cw);
		for (int i = 0; i < SYN_W; i++) begin
			if ((1 << i) < CODE_BITS) begin
				enc_cw[(1 << i) - 1] = enc_syn[i];
			end
		end
		enc_cw[CODE_BITS-1] = ^enc_cw[CODE_BITS-2:0];
	end

	// decode: syndrome and overall parity, single flip or double flag
	always_comb begin
		dec_syn    = syndrome(code_s1);
		dec_par    = ^code_s1;
		dec_cw     = code_s1;
		dec_status = ST_OK;
		if (dec_par) begin
			if (dec_syn == '0) begin
				// error in the overall parity bit
				dec_cw[CODE_BITS-1] = ~code_s1[CODE_BITS-1];
				dec_status          = ST_CORRECTED;
			end else if (int'(dec_syn) < CODE_BITS) begin
				for (int pos = 1; pos < CODE_BITS; pos++) begin
					if (dec_syn == SYN_W'(pos)) begin
						dec_cw[pos-1] = ~code_s1[pos-1];
					end
				end
				dec_status = ST_CORRECTED;
			end else begin
				// syndrome names a position outside a shortened code
				dec_status = ST_DOUBLE;
			end
		end else if (dec_syn != '0) begin
			dec_status = ST_DOUBLE;
		end
	end

	// result select, unused upper port bits held at zero
	always_comb begin
		code_nxt   = '0;
		data_nxt   = '0;
		status_nxt = ST_OK;
		if (mode_t'(mode_s1) == MODE_ENCODE) begin
			code_nxt[CODE_BITS-1:0] = enc_cw;
		end else begin
			code_nxt[CODE_BITS-1:0] = dec_cw;
			data_nxt[DATA_BITS-1:0] = gather(dec_cw);
			status_nxt              = dec_status;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			code_q   <= code_nxt;
			data_q   <= data_nxt;
			status_q <= status_nxt;
		end
	end

	assign done     = done_q;
	assign code_out = code_q;
	assign data_out = data_q;
	assign status   = status_q;

endmodule

### test/testbench.sv
// self-checking testbench for the secded codec: encode and check/correct transactions
`timescale 1ns / 1ps

module testbench;
	import hsc_pkg::*;

	// one word presented to the codec
	typedef struct {
		mode_t             op;
		logic [DATA_W-1:0] data;
		logic [CODE_W-1:0] code;
	} codec_word_t;

	// what the codec should return for one word
	typedef struct {
		logic [CODE_W-1:0] code;
		logic [DATA_W-1:0] data;
		status_t           st;
	} codec_result_t;

	localparam int RANDOM_WORDS = 650;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	mode_t             mode = MODE_ENCODE;
	logic [DATA_W-1:0] data_in = '0;
	logic [CODE_W-1:0] code_in = '0;
	logic              done;
	logic [CODE_W-1:0] code_out;
	logic [DATA_W-1:0] data_out;
	logic [1:0]        status;

	codec_word_t   words_to_send[$];
	codec_result_t predicted_words[$];

	int n_total = 0;
	int n_issued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int mismatches = 0;
	int n_encode = 0;
	int n_clean = 0;
	int n_fixed = 0;
	int n_double = 0;

	hamming_secded_codec_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.data_in  (data_in),
		.code_in  (code_in),
		.done     (done),
		.code_out (code_out),
		.data_out (data_out),
		.status   (status)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// xor of the position numbers of all ones below the overall parity bit
	function automatic int unsigned position_xor(input logic [CODE_W-1:0] cw);
		int unsigned syn;
		syn = 0;
		for (int unsigned p = 1; p < CODE_BITS; p++) begin
			if (cw[p-1]) begin
				syn ^= p;
			end
		end
		return syn;
	endfunction

	// build a codeword: data at non-power-of-two positions, then check bits, then parity
	function automatic logic [CODE_W-1:0] secded_encode(input logic [DATA_W-1:0] word);
		logic [CODE_W-1:0] cw;
		int unsigned d;
		int unsigned syn;
		cw = '0;
		d = 0;
		for (int unsigned p = 1; p < CODE_BITS; p++) begin
			if ((p & (p - 1)) != 0 && d < DATA_BITS) begin
				cw[p-1] = word[d];
				d++;
			end
		end
		syn = position_xor(cw);
		for (int unsigned p = 1; p < CODE_BITS; p = p << 1) begin
			if ((syn & p) != 0) begin
				cw[p-1] = 1'b1;
			end
		end
		cw[CODE_BITS-1] = ^cw;
		return cw;
	endfunction

	// expected result of one transaction
	function automatic codec_result_t predict_codec(input codec_word_t w);
		codec_result_t r;
		logic [CODE_W-1:0] cw;
		int unsigned syn;
		int unsigned d;
		r.code = '0;
		r.data = '0;
		r.st = ST_OK;
		if (w.op == MODE_ENCODE) begin
			r.code = secded_encode(w.data);
		end else begin
			cw = w.code;
			for (int k = CODE_BITS; k < CODE_W; k++) begin
				cw[k] = 1'b0;
			end
			syn = position_xor(cw);
			// odd overall parity means one flipped bit, unless the syndrome is off the code
			if (^cw) begin
				if (syn == 0) begin
					cw[CODE_BITS-1] = ~cw[CODE_BITS-1];
					r.st = ST_CORRECTED;
				end else if (syn < CODE_BITS) begin
					cw[syn-1] = ~cw[syn-1];
					r.st = ST_CORRECTED;
				end else begin
					r.st = ST_DOUBLE;
				end
			end else if (syn != 0) begin
				r.st = ST_DOUBLE;
			end
			r.code = cw;
			d = 0;
			for (int unsigned p = 1; p < CODE_BITS; p++) begin
				if ((p & (p - 1)) != 0 && d < DATA_BITS) begin
					r.data[d] = cw[p-1];
					d++;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [CODE_W-1:0] rand_bits64();
		return {$urandom(), $urandom()};
	endfunction

	// flip n distinct code bits at random
	function automatic logic [CODE_W-1:0] flip_bits(input logic [CODE_W-1:0] cw, input int n);
		logic [CODE_W-1:0] hit;
		int k;
		hit = '0;
		while (n > 0) begin
			k = $urandom_range(0, CODE_BITS - 1);
			if (!hit[k]) begin
				hit[k] = 1'b1;
				n--;
			end
		end
		return cw ^ hit;
	endfunction

	task automatic queue_word(input mode_t op, input logic [DATA_W-1:0] d,
			input logic [CODE_W-1:0] c);
		codec_word_t w;
		w.op = op;
		w.data = d;
		w.code = c;
		words_to_send.push_back(w);
	endtask

	// driver: present queued words, idle at random per phase
	always @(posedge clk or negedge arst_n) begin
		codec_word_t   w;
		codec_result_t r;
		int            idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				w.op = mode;
				w.data = data_in;
				w.code = code_in;
				r = predict_codec(w);
				predicted_words.push_back(r);
				n_accepted++;
				if (w.op == MODE_ENCODE) begin
					n_encode++;
				end else begin
					case (r.st)
						ST_OK:        n_clean++;
						ST_CORRECTED: n_fixed++;
						default:      n_double++;
					endcase
				end
			end
			if (!start || !busy) begin
				if (n_issued < n_total / 3) begin
					idle_pct = 11;
				end else if (n_issued < 2 * n_total / 3) begin
					idle_pct = 76;
				end else begin
					idle_pct = 0;
				end
				if (words_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					w = words_to_send.pop_front();
					start <= 1'b1;
					mode <= w.op;
					data_in <= w.data;
					code_in <= w.code;
					n_issued++;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		codec_result_t r;
		if (arst_n && done) begin
			if (predicted_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: code_out %h data_out %h status %0d",
						code_out, data_out, status);
				end
			end else begin
				r = predicted_words.pop_front();
				n_checked++;
				if (code_out !== r.code || data_out !== r.data || status !== r.st) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on transaction %0d: got %h %h %0d, expected %h %h %0d",
							n_checked, code_out, data_out, status, r.code, r.data, r.st);
					end
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [CODE_W-1:0] good;
		int pick;
		good = secded_encode(DATA_W'(rand_bits64()));

		// directed: field extremes, both operations, each error class
		queue_word(MODE_ENCODE, '0, '0);
		queue_word(MODE_ENCODE, '1, '0);
		queue_word(MODE_ENCODE, 57'h155555555555555, '1);
		queue_word(MODE_ENCODE, 57'h0AAAAAAAAAAAAAA, rand_bits64());
		queue_word(MODE_ENCODE, 57'd1, '0);
		queue_word(MODE_ENCODE, 57'd1 << (DATA_W - 1), '0);
		queue_word(MODE_DECODE, '1, good);
		queue_word(MODE_DECODE, '0, '0);
		queue_word(MODE_DECODE, '0, '1);
		queue_word(MODE_DECODE, '0, good ^ 64'd1);
		queue_word(MODE_DECODE, '0, good ^ (64'd1 << 2));
		queue_word(MODE_DECODE, '0, good ^ (64'd1 << (CODE_BITS - 2)));
		// error on the overall parity bit alone
		queue_word(MODE_DECODE, '0, good ^ (64'd1 << (CODE_BITS - 1)));
		queue_word(MODE_DECODE, '0, 64'd1 << (CODE_BITS - 1));
		// double errors, including a data bit paired with the parity bit, then a triple error, a single flip and noise
		queue_word(MODE_DECODE, '0, good ^ 64'd3);
		queue_word(MODE_DECODE, '0, good ^ (64'd1 << 5) ^ (64'd1 << 40));
		queue_word(MODE_DECODE, '0, good ^ (64'd1 << 4) ^ (64'd1 << (CODE_BITS - 1)));
		queue_word(MODE_DECODE, '0, good ^ 64'd7);
		queue_word(MODE_DECODE, '1, secded_encode('1) ^ (64'd1 << 30));
		queue_word(MODE_DECODE, DATA_W'(rand_bits64()), rand_bits64());

		// random: mostly valid codewords with zero to three flips, some raw noise
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				queue_word(MODE_ENCODE, DATA_W'(rand_bits64()), rand_bits64());
			end else begin
				good = secded_encode(DATA_W'(rand_bits64()));
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					queue_word(MODE_DECODE, DATA_W'(rand_bits64()), good);
				end else if (pick < 60) begin
					queue_word(MODE_DECODE, DATA_W'(rand_bits64()), flip_bits(good, 1));
				end else if (pick < 85) begin
					queue_word(MODE_DECODE, DATA_W'(rand_bits64()), flip_bits(good, 2));
				end else if (pick < 90) begin
					queue_word(MODE_DECODE, DATA_W'(rand_bits64()), flip_bits(good, 3));
				end else begin
					queue_word(MODE_DECODE, DATA_W'(rand_bits64()), rand_bits64());
				end
			end
		end
		n_total = words_to_send.size();

		// hold reset at the start, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total) @(posedge clk);
		while (predicted_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d encode and %0d decode transactions, %0d results checked",
			n_encode, n_clean + n_fixed + n_double, n_checked);
		$display("decode outcomes: %0d clean, %0d corrected, %0d double errors, %0d mismatches",
			n_clean, n_fixed, n_double, mismatches);
		if (mismatches == 0 && predicted_words.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("timeout after %0d of %0d transactions", n_accepted, n_total);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
